>>> rtl/rgba_alpha_over_compositor_top_macros.svh
// assertion macros for the alpha-over compositor
`ifndef RGBA_ALPHA_OVER_COMPOSITOR_TOP_MACROS_SVH
`define RGBA_ALPHA_OVER_COMPOSITOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define RAOC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compositor assertion failed");

// implication a fixed number of cycles later
`define RAOC_ASSERT_DELAY(label, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("compositor assertion failed");

`endif

>>> rtl/raoc_pkg.sv
// shared constants and types for the alpha-over compositor
package raoc_pkg;

    localparam int COORD_BITS = 16;
    localparam int SHIFT_W    = COORD_BITS + 1;
    localparam int SUM_W      = COORD_BITS + 2;
    localparam int CFG_W      = SHIFT_W;
    localparam int CFG_IDX_W  = 3;

    localparam int PIX_W      = 8;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int NUM_W      = 3 * PIX_W;
    localparam int DIVIDEND_W = NUM_W + 1;
    localparam int DIVISOR_W  = PROD_W + 1;
    localparam int QUO_W      = PIX_W;

    // total cycles from accept to result strobe
    localparam int LATENCY    = 2 + QUO_W;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE  = 3'd4;

    localparam logic MODE_COPY = 1'b0;
    localparam logic MODE_OVER = 1'b1;

    // per-word control carried alongside the divider lanes
    typedef struct packed {
        logic                  in_base;
        logic                  blend;
        logic                  den_zero;
        logic [COORD_BITS-1:0] dest_col;
        logic [COORD_BITS-1:0] dest_row;
        logic [PIX_W-1:0]      red;
        logic [PIX_W-1:0]      green;
        logic [PIX_W-1:0]      blue;
        logic [PIX_W-1:0]      alpha;
    } side_t;

endpackage

>>> rtl/raoc_div_lane.sv
// pipelined restoring divider, one quotient bit per stage
module raoc_div_lane
    import raoc_pkg::*;
(
    input  logic                  clk,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [QUO_W-1:0]      quotient
);

    logic [DIVIDEND_W-1:0] rem_reg [QUO_W-1];
    logic [DIVISOR_W-1:0]  div_reg [QUO_W-1];
    logic [QUO_W-1:0]      quo_reg [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_step
            logic [DIVIDEND_W-1:0] rem_in;
            logic [DIVISOR_W-1:0]  div_in;
            logic [QUO_W-1:0]      q_in;
            logic [DIVIDEND_W-1:0] trial;
            logic                  fits;

            if (k == 0)
            begin : g_first
                assign rem_in = dividend;
                assign div_in = divisor;
                assign q_in   = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign div_in = div_reg[k-1];
                assign q_in   = quo_reg[k-1];
            end

            // quotient never exceeds 8 bits, so the shifted divisor cannot overflow
            assign trial = {{(DIVIDEND_W-DIVISOR_W){1'b0}}, div_in} << (QUO_W - 1 - k);
            assign fits  = (rem_in >= trial);

            always_ff @(posedge clk)
            begin
                quo_reg[k] <= {q_in[QUO_W-2:0], fits};
            end

            if (k < QUO_W - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    rem_reg[k] <= fits ? (rem_in - trial) : rem_in;
                    div_reg[k] <= div_in;
                end
            end
        end
    endgenerate

    assign quotient = quo_reg[QUO_W-1];

endmodule

>>> rtl/rgba_alpha_over_compositor_top.sv
// top level of the rgba alpha-over compositor
// Usage:
//   A pixel word is taken when start is high and busy is low; busy is always
//   low, so a new word may be offered on every clock. Each word carries the
//   overlay coordinates, the overlay pixel and the base pixel beneath it.
//   Exactly one result word follows each accepted word and is shown for
//   one cycle with done high. Throughput is one word per
//   cycle. Latency is set by two product/sum stages followed by an eight
//   stage restoring divider, one quotient bit per stage, with three lanes
//   (one per colour) running side by side; the blended alpha is finished
//   in the second stage and rides along with the control.
//   Registers are written through cfg_we / cfg_index / cfg_data and should
//   only change while no word is in flight. Indices past blend_mode are
//   ignored. Reset clears the pipeline valid bits and loads width 1,
//   height 1, zero shifts and over mode. The receiver cannot stall, so
//   results are never held back.
`include "rgba_alpha_over_compositor_top_macros.svh"

module rgba_alpha_over_compositor_top
    import raoc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] overlay_col,
    input  logic [COORD_BITS-1:0] overlay_row,
    input  logic [PIX_W-1:0]      overlay_red,
    input  logic [PIX_W-1:0]      overlay_green,
    input  logic [PIX_W-1:0]      overlay_blue,
    input  logic [PIX_W-1:0]      overlay_alpha,
    input  logic [PIX_W-1:0]      base_red,
    input  logic [PIX_W-1:0]      base_green,
    input  logic [PIX_W-1:0]      base_blue,
    input  logic [PIX_W-1:0]      base_alpha,
    output logic                  done,
    output logic                  inside_res,
    output logic [COORD_BITS-1:0] dest_col,
    output logic [COORD_BITS-1:0] dest_row,
    output logic [PIX_W-1:0]      out_red,
    output logic [PIX_W-1:0]      out_green,
    output logic [PIX_W-1:0]      out_blue,
    output logic [PIX_W-1:0]      out_alpha
);

    // configuration
    logic [COORD_BITS-1:0] width_reg;
    logic [COORD_BITS-1:0] height_reg;
    logic [SHIFT_W-1:0]    shift_x_reg;
    logic [SHIFT_W-1:0]    shift_y_reg;
    logic                  mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= COORD_BITS'(1);
            height_reg  <= COORD_BITS'(1);
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            mode_reg    <= MODE_OVER;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_WIDTH:  width_reg   <= cfg_data[COORD_BITS-1:0];
                REG_BASE_HEIGHT: height_reg  <= cfg_data[COORD_BITS-1:0];
                REG_SHIFT_X:     shift_x_reg <= cfg_data[SHIFT_W-1:0];
                REG_SHIFT_Y:     shift_y_reg <= cfg_data[SHIFT_W-1:0];
                REG_BLEND_MODE:  mode_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // stage 1: placement, inside test and first products
    logic [SUM_W-1:0] dx;
    logic [SUM_W-1:0] dy;
    logic             inside_now;
    logic [PIX_W-1:0] inv_alpha;

    assign dx = {shift_x_reg[SHIFT_W-1], shift_x_reg} + {2'b00, overlay_col};
    assign dy = {shift_y_reg[SHIFT_W-1], shift_y_reg} + {2'b00, overlay_row};
    assign inside_now = !dx[SUM_W-1] && !dy[SUM_W-1]
                        && (dx[SUM_W-2:0] < {1'b0, width_reg})
                        && (dy[SUM_W-2:0] < {1'b0, height_reg});
    assign inv_alpha = PIX_W'(255) - overlay_alpha;

    logic              s1_valid_reg;
    side_t             s1_side_reg;
    logic [PROD_W-1:0] s1_ps_r_reg, s1_ps_g_reg, s1_ps_b_reg;
    logic [PROD_W-1:0] s1_pd_reg;
    logic [PIX_W-1:0]  s1_cd_r_reg, s1_cd_g_reg, s1_cd_b_reg;
    logic [PIX_W-1:0]  s1_as_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg.in_base  <= inside_now;
        s1_side_reg.blend    <= mode_reg;
        s1_side_reg.den_zero <= 1'b0;
        s1_side_reg.dest_col <= dx[COORD_BITS-1:0];
        s1_side_reg.dest_row <= dy[COORD_BITS-1:0];
        s1_side_reg.red      <= overlay_red;
        s1_side_reg.green    <= overlay_green;
        s1_side_reg.blue     <= overlay_blue;
        s1_side_reg.alpha    <= overlay_alpha;
        s1_ps_r_reg <= overlay_red * overlay_alpha;
        s1_ps_g_reg <= overlay_green * overlay_alpha;
        s1_ps_b_reg <= overlay_blue * overlay_alpha;
        s1_pd_reg   <= base_alpha * inv_alpha;
        s1_cd_r_reg <= base_red;
        s1_cd_g_reg <= base_green;
        s1_cd_b_reg <= base_blue;
        s1_as_reg   <= overlay_alpha;
    end

    // stage 2: numerators, denominator and divider operands
    logic [PROD_W-1:0] den;
    logic [NUM_W-1:0]  num_r, num_g, num_b;

    assign den = PROD_W'(({8'd0, s1_as_reg} << 8) - {8'd0, s1_as_reg}) + s1_pd_reg;
    assign num_r = (({8'd0, s1_ps_r_reg} << 8) - {8'd0, s1_ps_r_reg})
                   + (s1_cd_r_reg * s1_pd_reg);
    assign num_g = (({8'd0, s1_ps_g_reg} << 8) - {8'd0, s1_ps_g_reg})
                   + (s1_cd_g_reg * s1_pd_reg);
    assign num_b = (({8'd0, s1_ps_b_reg} << 8) - {8'd0, s1_ps_b_reg})
                   + (s1_cd_b_reg * s1_pd_reg);

    // (2d+255)/510 equals (d+127)/255, taken as (y + (y>>8) + 1) >> 8
    logic [DIVISOR_W-1:0] alpha_sum;
    logic [DIVISOR_W-1:0] alpha_est;

    assign alpha_sum = {1'b0, den} + DIVISOR_W'(127);
    assign alpha_est = alpha_sum + (alpha_sum >> 8) + DIVISOR_W'(1);

    logic                  s2_valid_reg;
    side_t                 s2_side_reg;
    side_t                 s2_side_next;
    logic [DIVIDEND_W-1:0] s2_dd_r_reg, s2_dd_g_reg, s2_dd_b_reg;
    logic [DIVISOR_W-1:0]  s2_dv_reg;

    always_comb
    begin
        s2_side_next          = s1_side_reg;
        s2_side_next.den_zero = (den == '0);
        if (s1_side_reg.blend == MODE_OVER)
            s2_side_next.alpha = alpha_est[2*PIX_W-1:PIX_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    // dividend 2n+d over divisor 2d gives half-up rounding
    always_ff @(posedge clk)
    begin
        s2_side_reg <= s2_side_next;
        s2_dd_r_reg <= {num_r, 1'b0} + {{(DIVIDEND_W-PROD_W){1'b0}}, den};
        s2_dd_g_reg <= {num_g, 1'b0} + {{(DIVIDEND_W-PROD_W){1'b0}}, den};
        s2_dd_b_reg <= {num_b, 1'b0} + {{(DIVIDEND_W-PROD_W){1'b0}}, den};
        s2_dv_reg   <= {den, 1'b0};
    end

    // divider lanes
    logic [QUO_W-1:0] q_r, q_g, q_b;

    raoc_div_lane u_lane_r (.clk(clk), .dividend(s2_dd_r_reg), .divisor(s2_dv_reg),
                            .quotient(q_r));
    raoc_div_lane u_lane_g (.clk(clk), .dividend(s2_dd_g_reg), .divisor(s2_dv_reg),
                            .quotient(q_g));
    raoc_div_lane u_lane_b (.clk(clk), .dividend(s2_dd_b_reg), .divisor(s2_dv_reg),
                            .quotient(q_b));

    // control travelling beside the lanes
    logic  vld_reg  [QUO_W];
    side_t side_reg [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_side
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (k == 0)
                    vld_reg[k] <= s2_valid_reg;
                else
                    vld_reg[k] <= vld_reg[(k == 0) ? 0 : k - 1];
            end

            always_ff @(posedge clk)
            begin
                if (k == 0)
                    side_reg[k] <= s2_side_reg;
                else
                    side_reg[k] <= side_reg[(k == 0) ? 0 : k - 1];
            end
        end
    endgenerate

    // result selection
    side_t fin;
    assign fin  = side_reg[QUO_W-1];
    assign done = vld_reg[QUO_W-1];

    always_comb
    begin
        inside_res = fin.in_base;
        dest_col   = '0;
        dest_row   = '0;
        out_red    = '0;
        out_green  = '0;
        out_blue   = '0;
        out_alpha  = '0;
        if (fin.in_base)
        begin
            dest_col  = fin.dest_col;
            dest_row  = fin.dest_row;
            out_alpha = fin.alpha;
            if (fin.blend == MODE_COPY)
            begin
                out_red   = fin.red;
                out_green = fin.green;
                out_blue  = fin.blue;
            end
            else if (!fin.den_zero)
            begin
                out_red   = q_r;
                out_green = q_g;
                out_blue  = q_b;
            end
        end
    end

    `RAOC_ASSERT_DELAY(a_word_returns, accept, 10, done)
    `RAOC_ASSERT_IMPLY(a_no_spurious, done, $past(accept, LATENCY))
    `RAOC_ASSERT_IMPLY(a_outside_zero, done && !inside_res,
                       dest_col == '0 && dest_row == '0 && out_alpha == '0)

endmodule
